[rtl/core/assert_macros.svh]
// Assertion helper macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/md5_pkg.sv]
`timescale 1ns / 1ps
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_part;
    logic        part_last;
  } out_item_t;

  // Command from the front part to the compression engine.
  typedef struct packed {
    logic [511:0] block;
    logic         finish;
  } blk_cmd_t;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;

  // Round constants.
  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Rotate amount per round.
  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
      4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
      4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/md5_front.sv]
`timescale 1ns / 1ps
// Collects bytes into a block, counts the length, and issues full and padded blocks.
module md5_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  md5_pkg::in_item_t   item_i,
  output logic                full_o,
  output logic                cmd_valid_o,
  output md5_pkg::blk_cmd_t   cmd_o,
  input  logic                cmd_ready_i
);

  typedef enum logic [2:0] {
    StCollect = 3'b001,
    StPad     = 3'b010,
    StLen     = 3'b100
  } fr_state_e;

  fr_state_e    state_q, state_d;
  logic [511:0] buf_q, buf_d;
  logic [5:0]   fill_q, fill_d;
  logic [63:0]  len_q, len_d;
  logic         cmd_valid_q, cmd_valid_d;
  md5_pkg::blk_cmd_t cmd_q, cmd_d;
  logic         accept;
  logic         slot_free;
  logic [511:0] pad_blk;
  logic [63:0]  len_next;

  assign slot_free = !cmd_valid_q || cmd_ready_i;
  assign full_o    = (state_q != StCollect) || !slot_free;
  assign accept    = push_i && !full_o;
  assign len_next  = len_q + 64'd8;

  // Padding of the current buffer: 0x80 at fill, zeros above.
  always_comb begin
    pad_blk = buf_q;
    for (int j = 0; j < 64; j++) begin
      if (6'(j) == fill_q) begin
        pad_blk[8*j +: 8] = md5_pkg::PadByte;
      end else if (6'(j) > fill_q) begin
        pad_blk[8*j +: 8] = 8'h00;
      end
    end
  end

  // Byte collection and block issue.
  always_comb begin
    state_d     = state_q;
    buf_d       = buf_q;
    fill_d      = fill_q;
    len_d       = len_q;
    cmd_d       = cmd_q;
    cmd_valid_d = cmd_valid_q && !cmd_ready_i;
    unique case (state_q)
      StCollect: begin
        if (accept) begin
          buf_d[8*fill_q +: 8] = item_i.data_byte;
          fill_d = fill_q + 6'd1;
          len_d  = len_next;
          if (fill_q == 6'd63) begin
            cmd_d.block  = buf_d;
            cmd_d.finish = 1'b0;
            cmd_valid_d  = 1'b1;
            fill_d       = 6'd0;
          end
          if (item_i.is_last) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        if (slot_free) begin
          if (fill_q >= 6'd56) begin
            cmd_d.block  = pad_blk;
            cmd_d.finish = 1'b0;
            cmd_valid_d  = 1'b1;
            buf_d        = '0;
            state_d      = StLen;
          end else begin
            cmd_d.block  = {len_q, pad_blk[447:0]};
            cmd_d.finish = 1'b1;
            cmd_valid_d  = 1'b1;
            state_d      = StCollect;
            fill_d       = 6'd0;
            len_d        = '0;
          end
        end
      end
      StLen: begin
        if (slot_free) begin
          cmd_d.block  = {len_q, buf_q[447:0]};
          cmd_d.finish = 1'b1;
          cmd_valid_d  = 1'b1;
          state_d      = StCollect;
          fill_d       = 6'd0;
          len_d        = '0;
        end
      end
      default: state_d = StCollect;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StCollect;
      fill_q      <= '0;
      len_q       <= '0;
      cmd_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

endmodule

[rtl/core/md5_engine.sv]
`timescale 1ns / 1ps
// Runs one MD5 round per cycle and emits the digest in two halves.
module md5_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  md5_pkg::blk_cmd_t   cmd_i,
  output logic                cmd_ready_o,
  input  logic                pop_i,
  output logic                empty_o,
  output md5_pkg::out_item_t  item_o
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StRound = 4'b0010,
    StOut0  = 4'b0100,
    StOut1  = 4'b1000
  } en_state_e;

  en_state_e    state_q, state_d;
  logic [511:0] blk_q, blk_d;
  logic         fin_q, fin_d;
  logic [5:0]   rnd_q, rnd_d;
  logic [31:0]  a_q, b_q, c_q, d_q, a_d, b_d, c_d, d_d;
  logic [31:0]  h0_q, h1_q, h2_q, h3_q, h0_d, h1_d, h2_d, h3_d;
  logic [31:0]  f, t, rot;
  logic [3:0]   g;
  logic [4:0]   s;

  // Round function.
  always_comb begin
    unique case (rnd_q[5:4])
      2'd0: begin f = (b_q & c_q) | (~b_q & d_q); g = rnd_q[3:0]; end
      2'd1: begin f = (d_q & b_q) | (~d_q & c_q); g = 4'(5 * rnd_q + 1); end
      2'd2: begin f = b_q ^ c_q ^ d_q; g = 4'(3 * rnd_q + 5); end
      default: begin f = c_q ^ (b_q | ~d_q); g = 4'(7 * rnd_q); end
    endcase
    s   = md5_pkg::round_s(rnd_q);
    t   = a_q + f + md5_pkg::round_k(rnd_q) + blk_q[32*g +: 32];
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
  end

  assign cmd_ready_o = (state_q == StIdle);
  assign empty_o     = !((state_q == StOut0) || (state_q == StOut1));
  assign item_o.digest_part = (state_q == StOut1) ? {h3_q, h2_q} : {h1_q, h0_q};
  assign item_o.part_last   = (state_q == StOut1);

  always_comb begin
    state_d = state_q;
    blk_d = blk_q; fin_d = fin_q; rnd_d = rnd_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q;
    h0_d = h0_q; h1_d = h1_q; h2_d = h2_q; h3_d = h3_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          blk_d = cmd_i.block; fin_d = cmd_i.finish; rnd_d = '0;
          a_d = h0_q; b_d = h1_q; c_d = h2_q; d_d = h3_q;
          state_d = StRound;
        end
      end
      StRound: begin
        a_d = d_q; d_d = c_q; c_d = b_q; b_d = b_q + rot;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          h0_d = h0_q + d_q; h1_d = h1_q + b_q + rot;
          h2_d = h2_q + b_q; h3_d = h3_q + c_q;
          state_d = fin_q ? StOut0 : StIdle;
        end
      end
      StOut0: if (pop_i) state_d = StOut1;
      StOut1: begin
        if (pop_i) begin
          h0_d = md5_pkg::Iv0; h1_d = md5_pkg::Iv1;
          h2_d = md5_pkg::Iv2; h3_d = md5_pkg::Iv3;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      h0_q <= md5_pkg::Iv0; h1_q <= md5_pkg::Iv1;
      h2_q <= md5_pkg::Iv2; h3_q <= md5_pkg::Iv3;
      rnd_q <= '0;
    end else begin
      state_q <= state_d;
      h0_q <= h0_d; h1_q <= h1_d; h2_q <= h2_d; h3_q <= h3_d;
      rnd_q <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d; fin_q <= fin_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
  end

endmodule

[rtl/core/md5_stream_hasher_top.sv]
`timescale 1ns / 1ps
// Streaming MD5 hasher: one byte per transfer, digest in two 64-bit results.
// Bytes are taken one per cycle while the block register slot is free and no
// padding block is pending; the one-round-per-cycle engine takes a new block
// only when idle, after all rounds of the last one and after a final digest
// is popped. Reset (asynchronous, active low) loads the chain.
module md5_stream_hasher_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  md5_pkg::in_item_t   in_item_i,
  output logic                empty,
  input  logic                pop,
  output md5_pkg::out_item_t  out_item_o
);

  logic              cmd_valid, cmd_ready;
  md5_pkg::blk_cmd_t cmd;

  md5_front u_front (
    .clk_i, .rst_ni, .push_i(push), .item_i(in_item_i), .full_o(full),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready)
  );

  md5_engine u_engine (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready),
    .pop_i(pop), .empty_o(empty), .item_o(out_item_o)
  );

endmodule

[rtl/core/md5_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Port-level checks of the hasher.
module md5_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input md5_pkg::out_item_t out_item_o
);
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_item_o))
  `ASSERT_NEXT(a_pair, clk_i, rst_ni, !empty && pop && !out_item_o.part_last, !empty && out_item_o.part_last)
  `ASSERT_NEXT(a_gap, clk_i, rst_ni, !empty && pop && out_item_o.part_last, empty)
endmodule

bind md5_stream_hasher_top md5_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .out_item_o
);
